FILE: sv/tcpq_pkg.sv
// Shared types and constants of the two-class priority queue with aging.
`timescale 1ns / 1ps
package tcpq_pkg;

  localparam int unsigned TicketW = 16;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned AgeW    = 7;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned OccW    = 5;

  localparam logic [AgeW-1:0]   AgeThresholdRst = 7'd60;
  localparam logic [LimitW-1:0] WaitLimitRst    = 16'd120;

  typedef enum logic [1:0] {
    ACT_ENQUEUE   = 2'd0,
    ACT_DEQUEUE   = 2'd1,
    ACT_AGE_CHECK = 2'd2,
    ACT_EMERGENCY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    REG_AGE_THRESHOLD = 1'b0,
    REG_WAIT_LIMIT    = 1'b1
  } reg_e;

  // Sort keys: lower keys move toward the head, equal keys keep their order.
  localparam logic [1:0] KeyFirst  = 2'd0;
  localparam logic [1:0] KeySecond = 2'd1;
  localparam logic [1:0] KeyNormal = 2'd2;
  localparam logic [1:0] KeyEmpty  = 2'd3;

  typedef enum logic [2:0] {
    C_NOP,
    C_ENQ,
    C_DEQ,
    C_CLR,
    C_SEARCH,
    C_AGE,
    C_EMG,
    C_SORT
  } cop_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_SORT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [AgeW-1:0]    age;
    logic               health_worker;
    logic [TicketW-1:0] ticket;
    logic [TimeW-1:0]   time_now;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TicketW-1:0] out_ticket;
    logic               out_priority;
    logic               out_emergency;
    logic [OccW-1:0]    occupancy;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [TicketW-1:0] ticket;
    logic [TimeW-1:0]   tstamp;
    logic               pr;
    logic               em;
    logic [1:0]         key;
  } entry_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    entry_t e;
    logic   chain;
  } link_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    cop_e               op;
    logic [TicketW-1:0] ticket;
    logic [TimeW-1:0]   tstamp;
    logic               pr;
    logic [LimitW-1:0]  limit;
  } cmd_t;

endpackage

FILE: sv/tcpq_cell.sv
// One queue position: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module tcpq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcpq_pkg::cmd_t   cmd_i,
  input  tcpq_pkg::link_t  left_i,
  input  tcpq_pkg::link_t  right_i,
  input  logic             left_role_i,
  output tcpq_pkg::link_t  link_o
);

  tcpq_pkg::entry_t ent_q, ent_d, cur;
  logic valid_q;
  logic prior_q, prior_d;
  logic match, first, promo, cond_self, cond_left;
  logic [tcpq_pkg::TimeW-1:0] wait_t;

  always_comb begin
    cur = ent_q;
    cur.valid = valid_q;
  end

  assign match = cur.valid && (cur.ticket == cmd_i.ticket);
  assign first = match && !prior_q;
  assign wait_t = cmd_i.tstamp - cur.tstamp;
  assign promo = cur.valid && !cur.pr && (cmd_i.tstamp > cur.tstamp)
               && (wait_t > cmd_i.limit);
  // Insert point of a new entry is the first cell where this turns true.
  assign cond_self = !cur.valid || (cmd_i.pr && !cur.pr);
  assign cond_left = !left_i.e.valid || (cmd_i.pr && !left_i.e.pr);

  assign link_o.e = cur;
  assign link_o.chain = prior_q || match;

  always_comb begin
    ent_d = cur;
    prior_d = prior_q;
    case (cmd_i.op)
      tcpq_pkg::C_ENQ: begin
        if (cond_left) begin
          ent_d = left_i.e;
        end else if (cond_self) begin
          ent_d.valid = 1'b1;
          ent_d.ticket = cmd_i.ticket;
          ent_d.tstamp = cmd_i.tstamp;
          ent_d.pr = cmd_i.pr;
          ent_d.em = 1'b0;
        end
      end
      tcpq_pkg::C_DEQ: ent_d = right_i.e;
      tcpq_pkg::C_CLR: prior_d = 1'b0;
      tcpq_pkg::C_SEARCH: prior_d = left_i.chain;
      tcpq_pkg::C_AGE: begin
        if (!cur.valid) begin
          ent_d.key = tcpq_pkg::KeyEmpty;
        end else if (promo) begin
          ent_d.key = tcpq_pkg::KeyFirst;
          ent_d.pr = 1'b1;
        end else if (cur.pr) begin
          ent_d.key = tcpq_pkg::KeySecond;
        end else begin
          ent_d.key = tcpq_pkg::KeyNormal;
        end
      end
      tcpq_pkg::C_EMG: begin
        if (!cur.valid) begin
          ent_d.key = tcpq_pkg::KeyEmpty;
        end else if (first) begin
          ent_d.key = tcpq_pkg::KeySecond;
          ent_d.pr = 1'b1;
          ent_d.em = 1'b1;
        end else if (cur.pr) begin
          ent_d.key = tcpq_pkg::KeyFirst;
        end else begin
          ent_d.key = tcpq_pkg::KeyNormal;
        end
      end
      tcpq_pkg::C_SORT: begin
        if (left_role_i) begin
          if (cur.key > right_i.e.key) ent_d = right_i.e;
        end else begin
          if (left_i.e.key > cur.key) ent_d = left_i.e;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prior_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
      prior_q <= prior_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

FILE: sv/two_class_priority_queue_aging_core.sv
// Top level of the two-class priority queue with aging: control and a row of cells.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------
//  input    | in_valid_i / in_stall_o   | in_data_i  (tcpq_pkg::in_t)
//  result   | out_valid_o / out_stall_i | out_data_o (tcpq_pkg::out_t)
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Enqueue, dequeue and an emergency on an empty queue are answered straight from idle.
// Age check marks the entries, then runs DEPTH odd-even sort rounds.
// Emergency runs a search ripple, then, if the ticket is found, marks entries and sorts.
// Reset clears the valid bits of all cells and loads the register defaults.
// A stalled result holds its register; a new beat is taken only while idle and
// the result register is free or draining.
`timescale 1ns / 1ps
module two_class_priority_queue_aging_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcpq_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcpq_pkg::out_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [tcpq_pkg::LimitW-1:0] cfg_data_i
);

  localparam int unsigned CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  tcpq_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] count_q, count_d;
  logic phase_q, phase_d;
  logic found_q, found_d;
  logic [tcpq_pkg::TicketW-1:0] tkt_q, tkt_d;
  logic [tcpq_pkg::AgeW-1:0] age_thr_q;
  logic [tcpq_pkg::LimitW-1:0] limit_q;
  tcpq_pkg::out_t res_q, res_d;
  tcpq_pkg::out_t out_q, out_d;
  logic out_valid_q, out_load;
  logic acc, enq_pr, busy_out;
  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::link_t links [DEPTH];
  tcpq_pkg::link_t lefts [DEPTH];
  tcpq_pkg::link_t rights [DEPTH];

  assign busy_out = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != tcpq_pkg::S_IDLE) || busy_out;
  assign acc = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign cfg_ready_o = 1'b1;
  assign enq_pr = (in_data_i.age >= age_thr_q) || in_data_i.health_worker;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_thr_q <= tcpq_pkg::AgeThresholdRst;
      limit_q <= tcpq_pkg::WaitLimitRst;
    end else if (cfg_valid_i) begin
      unique case (tcpq_pkg::reg_e'(cfg_index_i))
        tcpq_pkg::REG_AGE_THRESHOLD: age_thr_q <= cfg_data_i[tcpq_pkg::AgeW-1:0];
        tcpq_pkg::REG_WAIT_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Boundary links: the left end looks like a priority entry that never
  // moves, the right end like an empty slot.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        lefts[i] = '0;
        lefts[i].e.valid = 1'b1;
        lefts[i].e.pr = 1'b1;
        lefts[i].e.key = tcpq_pkg::KeyFirst;
      end else begin
        lefts[i] = links[i-1];
      end
      if (i == DEPTH - 1) begin
        rights[i] = '0;
        rights[i].e.key = tcpq_pkg::KeyEmpty;
      end else begin
        rights[i] = links[i+1];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    tcpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (lefts[g]),
      .right_i     (rights[g]),
      .left_role_i (1'(g % 2) == phase_q),
      .link_o      (links[g])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpq_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data_i.action == tcpq_pkg::ACT_AGE_CHECK) begin
            state_d = tcpq_pkg::S_SORT;
          end else if (in_data_i.action == tcpq_pkg::ACT_EMERGENCY && count_q != '0) begin
            state_d = tcpq_pkg::S_SEARCH;
          end
        end
      end
      tcpq_pkg::S_SEARCH: if (cnt_q == '0) state_d = tcpq_pkg::S_CHECK;
      tcpq_pkg::S_CHECK: state_d = found_q ? tcpq_pkg::S_SORT : tcpq_pkg::S_RESULT;
      tcpq_pkg::S_SORT: if (cnt_q == '0) state_d = tcpq_pkg::S_RESULT;
      tcpq_pkg::S_RESULT: if (!busy_out) state_d = tcpq_pkg::S_IDLE;
      default: state_d = tcpq_pkg::S_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    cmd.op = tcpq_pkg::C_NOP;
    cmd.ticket = tkt_q;
    cmd.tstamp = in_data_i.time_now;
    cmd.pr = enq_pr;
    cmd.limit = limit_q;
    cnt_d = cnt_q;
    count_d = count_q;
    phase_d = phase_q;
    found_d = found_q;
    tkt_d = tkt_q;
    res_d = res_q;
    out_load = 1'b0;
    out_d = '0;
    unique case (state_q)
      tcpq_pkg::S_IDLE: begin
        cmd.ticket = in_data_i.ticket;
        cnt_d = CW'(DEPTH - 1);
        phase_d = 1'b0;
        if (acc) begin
          unique case (tcpq_pkg::action_e'(in_data_i.action))
            tcpq_pkg::ACT_ENQUEUE: begin
              out_load = 1'b1;
              if (count_q == NW'(DEPTH)) begin
                out_d.status = tcpq_pkg::ST_FULL;
              end else begin
                cmd.op = tcpq_pkg::C_ENQ;
                count_d = count_q + NW'(1);
                out_d.out_ticket = in_data_i.ticket;
                out_d.out_priority = enq_pr;
              end
            end
            tcpq_pkg::ACT_DEQUEUE: begin
              out_load = 1'b1;
              if (count_q == '0) begin
                out_d.status = tcpq_pkg::ST_EMPTY;
              end else begin
                cmd.op = tcpq_pkg::C_DEQ;
                count_d = count_q - NW'(1);
                out_d.out_ticket = links[0].e.ticket;
                out_d.out_priority = links[0].e.pr;
                out_d.out_emergency = links[0].e.em;
              end
            end
            tcpq_pkg::ACT_AGE_CHECK: begin
              cmd.op = tcpq_pkg::C_AGE;
              res_d = '0;
            end
            tcpq_pkg::ACT_EMERGENCY: begin
              if (count_q == '0) begin
                out_load = 1'b1;
                out_d.status = tcpq_pkg::ST_NOT_FOUND;
              end else begin
                cmd.op = tcpq_pkg::C_CLR;
                tkt_d = in_data_i.ticket;
                found_d = 1'b0;
              end
            end
            default: ;
          endcase
          out_d.occupancy = tcpq_pkg::OccW'(count_d);
        end
      end
      tcpq_pkg::S_SEARCH: begin
        cmd.op = tcpq_pkg::C_SEARCH;
        found_d = links[DEPTH-1].chain;
        cnt_d = cnt_q - CW'(1);
      end
      tcpq_pkg::S_CHECK: begin
        cnt_d = CW'(DEPTH - 1);
        res_d = '0;
        if (found_q) begin
          cmd.op = tcpq_pkg::C_EMG;
          res_d.out_ticket = tkt_q;
          res_d.out_priority = 1'b1;
          res_d.out_emergency = 1'b1;
        end else begin
          res_d.status = tcpq_pkg::ST_NOT_FOUND;
        end
      end
      tcpq_pkg::S_SORT: begin
        cmd.op = tcpq_pkg::C_SORT;
        phase_d = !phase_q;
        cnt_d = cnt_q - CW'(1);
      end
      tcpq_pkg::S_RESULT: begin
        if (!busy_out) begin
          out_load = 1'b1;
          out_d = res_q;
          out_d.occupancy = tcpq_pkg::OccW'(count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcpq_pkg::S_IDLE;
      count_q <= '0;
      out_valid_q <= 1'b0;
      cnt_q <= '0;
      phase_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      found_q <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tkt_q <= tkt_d;
    res_q <= res_d;
    if (out_load) out_q <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH)) else $error("occupancy beyond depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != tcpq_pkg::S_IDLE |=> $stable(count_q))
    else $error("occupancy changed during a multi-cycle operation");

  a_age_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.action == tcpq_pkg::ACT_AGE_CHECK |=> state_q == tcpq_pkg::S_SORT)
    else $error("age check did not start sorting");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !busy_out) else $error("result overwrote a stalled beat");

endmodule
